// ===== design/first_fit_heap_allocator_macros.svh =====
// Assertion macros for the heap allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Implication checked on every edge outside reset
`define FFHA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("%m: check failed");

// Implication whose consequent is checked in the following cycle
`define FFHA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("%m: check failed");

`endif

// ===== design/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;
   localparam int GranuleBytes = 16;
   localparam int PageBytes    = 4096;
   localparam int StatusWidth  = 3;
   localparam int OffsetWidth  = 20;
   localparam int SizeWidth    = 21;
   localparam int CountWidth   = 21;
   localparam int LiveWidth    = 16;

   typedef enum logic [1:0] {
      TAG_NONE = 2'd0,
      TAG_FREE = 2'd1,
      TAG_USED = 2'd2,
      TAG_RSVD = 2'd3
   } tag_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_NOFIT   = 3'd2,
      ST_NULL    = 3'd3,
      ST_DOUBLE  = 3'd4,
      ST_INVALID = 3'd5
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [SizeWidth-1:0]   size_bytes;
      logic                   ptr_null;
      logic [OffsetWidth-1:0] data_offset;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [OffsetWidth-1:0] alloc_offset;
      logic [CountWidth-1:0]  bytes_used;
      logic [CountWidth-1:0]  bytes_free;
      logic [LiveWidth-1:0]   blocks_live;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/ffha_req_if.sv =====
`default_nettype none
interface ffha_req_if;
   import ffha_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/ffha_rsp_if.sv =====
`default_nettype none
interface ffha_rsp_if;
   import ffha_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/first_fit_heap_allocator.sv =====
// Channel | Dir | Payload
// req     | in  | op, size_bytes, ptr_null, data_offset
// rsp     | out | status, alloc_offset, bytes_used, bytes_free, blocks_live
//
// After reset a clearing pass writes every header tag, one granule a cycle;
// no request is taken meanwhile. Zero-size allocates and null frees go straight
// to S_RSP. A free runs S_FCHK, then S_FWR unless the offset is rejected. An
// allocate runs S_RD and S_CHK per node visited, then on a fit S_SPLIT, plus
// S_LINK when the chosen block is not the list head (single read port).
// One request is in flight at a time; the result waits in an output register and
// a stalled result only holds back the next one.
`default_nettype none
module first_fit_heap_allocator #(
   parameter int HEAP_PAGE_COUNT = 256
) (
   input wire logic  clock,
   input wire logic  reset,
   ffha_req_if.sink  req,
   ffha_rsp_if.source rsp
);
   import ffha_pkg::*;

   localparam int Granules = HEAP_PAGE_COUNT * PageBytes / GranuleBytes;
   localparam int AW       = $clog2(Granules);
   localparam int LW       = AW + 1;
   localparam logic [LW-1:0] Nil = LW'(Granules);
   localparam logic [CountWidth-1:0] HeapBytes = CountWidth'(Granules * GranuleBytes);
   // entry: tag, length, next link
   localparam int EW = 2 + LW + LW;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_RD    = 9'b000000100,
      S_CHK   = 9'b000001000,
      S_SPLIT = 9'b000010000,
      S_LINK  = 9'b000100000,
      S_FCHK  = 9'b001000000,
      S_FWR   = 9'b010000000,
      S_RSP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0] need_ff, need_in;
   logic [LW-1:0] clr_ff, clr_in;
   logic [CountWidth-1:0] used_ff, used_in, free_ff, free_in;
   logic [LiveWidth-1:0] live_ff, live_in;
   logic [EW-1:0] ent_ff, ent_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type rsp_out_ff, rsp_out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic we;
   logic [AW-1:0] wa, ra;
   logic [EW-1:0] wd, rd;

   ffha_ram #(.Width(EW), .Depth(Granules)) u_hdr (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
   );

   logic [1:0] rd_tag;
   logic [LW-1:0] rd_len, rd_next;
   assign rd_tag  = rd[EW-1 -: 2];
   assign rd_len  = rd[2*LW-1 -: LW];
   assign rd_next = rd[LW-1:0];

   logic [CountWidth:0] gsum;
   logic [CountWidth-4:0] need_full;
   logic [LW:0] split_at;
   logic [LW-1:0] rem;
   logic [OffsetWidth-4:0] fg;
   logic [CountWidth-1:0] blk_bytes;
   assign gsum      = {1'b0, req_ff.size_bytes} + (CountWidth+1)'(15);
   assign need_full = gsum[CountWidth:4] + (CountWidth-3)'(1);
   assign split_at  = {1'b0, cur_ff} + {1'b0, need_ff};
   assign rem       = rd_len - need_ff;
   assign fg        = {1'b0, req_ff.data_offset[OffsetWidth-1:4]} - (OffsetWidth-3)'(1);
   assign blk_bytes = CountWidth'({rd_len, 4'b0000});

   always_comb begin
      state_in = state_ff; head_in = head_ff; cur_in = cur_ff; prev_in = prev_ff;
      need_in = need_ff; clr_in = clr_ff; used_in = used_ff; free_in = free_ff;
      live_in = live_ff; ent_in = ent_ff; req_in = req_ff; rsp_in = rsp_ff;
      rsp_out_in = rsp_out_ff; rsp_valid_in = rsp_valid_ff;
      we = 1'b0; wa = cur_ff[AW-1:0]; wd = '0; ra = cur_ff[AW-1:0];
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1; wa = clr_ff[AW-1:0];
            wd = (clr_ff == '0) ? {TAG_FREE, LW'(Granules), Nil} : {TAG_NONE, {2*LW{1'b0}}};
            clr_in = clr_ff + LW'(1);
            if (clr_ff == LW'(Granules - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               req_in = req.payload;
               rsp_in = '{status: ST_OK, alloc_offset: '0, bytes_used: used_ff,
                          bytes_free: free_ff, blocks_live: live_ff};
               state_in = S_RSP;
               if (req.payload.op == OP_ALLOC) begin
                  if (req.payload.size_bytes == '0) begin
                     rsp_in.status = ST_ZERO;
                  end else begin
                     cur_in = head_ff; prev_in = Nil; state_in = S_RD;
                  end
               end else if (req.payload.ptr_null) begin
                  rsp_in.status = ST_NULL;
               end else begin
                  state_in = S_FCHK; // next, check the offset and issue the header read
               end
            end
         end
         S_RD: begin
            // oversize requests get a need no block can meet
            need_in = (int'(need_full) > Granules) ? '1 : LW'(need_full);
            if (cur_ff >= Nil) begin
               rsp_in.status = ST_NOFIT; state_in = S_RSP;
            end else begin
               ra = cur_ff[AW-1:0]; state_in = S_CHK;
            end
         end
         S_CHK: begin
            ent_in = rd;
            if (rd_len >= need_ff) begin
               used_in = used_ff + CountWidth'({need_ff, 4'b0000});
               free_in = free_ff - CountWidth'({need_ff, 4'b0000});
               live_in = live_ff + LiveWidth'(1);
               rsp_in.alloc_offset = OffsetWidth'({cur_ff + LW'(1), 4'b0000});
               if (rem >= LW'(2) && split_at < (LW+1)'(Granules)) begin
                  we = 1'b1; wa = split_at[AW-1:0];
                  wd = {TAG_FREE, rem, rd_next};
                  ent_in = {TAG_USED, need_ff, Nil};
                  cur_in = split_at[LW-1:0]; // replacement link
                  prev_in = prev_ff;
                  need_in = cur_ff;           // block being allocated
               end else begin
                  used_in = used_ff + blk_bytes;
                  free_in = free_ff - blk_bytes;
                  ent_in = {TAG_USED, rd_len, Nil};
                  cur_in = rd_next;
                  need_in = cur_ff;
               end
               state_in = S_SPLIT;
            end else begin
               prev_in = cur_ff; cur_in = rd_next; state_in = S_RD;
            end
         end
         S_SPLIT: begin
            // mark the chosen block used
            we = 1'b1; wa = need_ff[AW-1:0]; wd = ent_ff;
            if (prev_ff == Nil) begin
               head_in = cur_ff; state_in = S_LINK;
               rsp_in.bytes_used = used_ff; rsp_in.bytes_free = free_ff;
               rsp_in.blocks_live = live_ff; state_in = S_RSP;
            end else begin
               ra = prev_ff[AW-1:0]; state_in = S_LINK;
            end
         end
         S_LINK: begin
            we = 1'b1; wa = prev_ff[AW-1:0];
            wd = {rd[EW-1 -: 2+LW], cur_ff};
            rsp_in.bytes_used = used_ff; rsp_in.bytes_free = free_ff;
            rsp_in.blocks_live = live_ff; state_in = S_RSP;
         end
         S_FCHK: begin
            if (req_ff.data_offset[3:0] != 4'd0 || req_ff.data_offset[OffsetWidth-1:4] == '0
                || int'(fg) >= Granules) begin
               rsp_in.status = ST_INVALID; state_in = S_RSP;
            end else begin
               ra = AW'(fg); cur_in = LW'(fg); state_in = S_FWR;
            end
         end
         S_FWR: begin
            if (tag_type'(rd_tag) == TAG_FREE) begin
               rsp_in.status = ST_DOUBLE;
            end else if (tag_type'(rd_tag) != TAG_USED) begin
               rsp_in.status = ST_INVALID;
            end else begin
               we = 1'b1; wa = cur_ff[AW-1:0]; wd = {TAG_FREE, rd_len, head_ff};
               head_in = cur_ff;
               used_in = used_ff - blk_bytes; free_in = free_ff + blk_bytes;
               live_in = live_ff - LiveWidth'(1);
               rsp_in.bytes_used = used_ff - blk_bytes;
               rsp_in.bytes_free = free_ff + blk_bytes;
               rsp_in.blocks_live = live_ff - LiveWidth'(1);
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            // load the output register once the previous beat has gone
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_out_in = rsp_ff; rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; head_ff <= '0;
         used_ff <= '0; free_ff <= HeapBytes; live_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; head_ff <= head_in;
         used_ff <= used_in; free_ff <= free_in; live_ff <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in; prev_ff <= prev_in; need_ff <= need_in;
      ent_ff <= ent_in; req_ff <= req_in; rsp_ff <= rsp_in; rsp_out_ff <= rsp_out_in;
   end
endmodule
`default_nettype wire

// ===== design/ffha_checker.sv =====
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"
module ffha_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire ffha_pkg::rsp_type              rsp_payload
);
   import ffha_pkg::*;
   `FFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `FFHA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `FFHA_ASSERT_IMP(a_offset_only_ok, clock, reset, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.alloc_offset == '0)
   `FFHA_ASSERT_IMP(a_status_range, clock, reset, rsp_valid, rsp_payload.status <= ST_INVALID)
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire

// ===== tb/sv/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int          PageCount    = 256;
   localparam int unsigned HeapGranules = PageCount * PageBytes / GranuleBytes;
   localparam int unsigned NilLink      = HeapGranules;
   localparam int unsigned HeapBytes    = HeapGranules * GranuleBytes;
   localparam int          RandomItems  = 400;

   logic clock;
   logic reset;

   ffha_req_if req_ch ();
   ffha_rsp_if rsp_ch ();

   first_fit_heap_allocator #(.HEAP_PAGE_COUNT(PageCount)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // shadow heap
   tag_type     shadow_tag  [HeapGranules];
   int unsigned shadow_len  [HeapGranules];
   int unsigned shadow_link [HeapGranules];
   int unsigned free_head;
   int unsigned shadow_used;
   int unsigned shadow_free;
   int unsigned live_count;

   rsp_type     pending_rsp [$];
   int unsigned live_ptrs   [$];
   int unsigned freed_ptrs  [$];
   int          error_count;
   int          burst_left;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic status_type heap_alloc(input int unsigned size,
                                             output int unsigned offset);
      int unsigned need, prev, cur, steps, len, rem, repl, nb;
      offset = 0;
      if (size == 0) return ST_ZERO;
      need  = 1 + (size + 15) / 16;
      prev  = NilLink;
      cur   = free_head;
      steps = 0;
      while (cur < HeapGranules && steps < HeapGranules) begin
         len = shadow_len[cur];
         if (len >= need) begin
            rem = len - need;
            if (rem >= 2 && cur + need < HeapGranules) begin
               nb              = cur + need;
               shadow_tag[nb]  = TAG_FREE;
               shadow_len[nb]  = rem;
               shadow_link[nb] = shadow_link[cur];
               shadow_len[cur] = need;
               repl            = nb;
            end else begin
               repl = shadow_link[cur];
            end
            if (prev == NilLink) free_head = repl;
            else shadow_link[prev] = repl;
            shadow_tag[cur]  = TAG_USED;
            shadow_link[cur] = NilLink;
            shadow_used += shadow_len[cur] * 16;
            shadow_free -= shadow_len[cur] * 16;
            live_count = (live_count + 1) & 16'hFFFF;
            offset     = (cur + 1) * 16;
            return ST_OK;
         end
         prev = cur;
         cur  = shadow_link[cur];
         steps++;
      end
      return ST_NOFIT;
   endfunction

   function automatic status_type heap_free(input logic is_null,
                                            input int unsigned doff);
      int unsigned g;
      if (is_null) return ST_NULL;
      if (doff < 16 || doff % 16 != 0) return ST_INVALID;
      g = doff / 16 - 1;
      if (g >= HeapGranules) return ST_INVALID;
      if (shadow_tag[g] == TAG_FREE) return ST_DOUBLE;
      if (shadow_tag[g] != TAG_USED) return ST_INVALID;
      shadow_tag[g]  = TAG_FREE;
      shadow_link[g] = free_head;
      free_head      = g;
      shadow_used -= shadow_len[g] * 16;
      shadow_free += shadow_len[g] * 16;
      live_count = (live_count - 1) & 16'hFFFF;
      return ST_OK;
   endfunction

   function automatic rsp_type heap_predict(input req_type r);
      rsp_type     o;
      int unsigned offset;
      status_type  st;
      offset = 0;
      if (r.op == OP_ALLOC) st = heap_alloc(r.size_bytes, offset);
      else st = heap_free(r.ptr_null, r.data_offset);
      o.status       = st;
      o.alloc_offset = offset[OffsetWidth-1:0];
      o.bytes_used   = shadow_used[CountWidth-1:0];
      o.bytes_free   = shadow_free[CountWidth-1:0];
      o.blocks_live  = live_count[LiveWidth-1:0];
      return o;
   endfunction

   function automatic void track_ptrs(input req_type r, input rsp_type o);
      if (o.status != ST_OK) return;
      if (r.op == OP_ALLOC) begin
         live_ptrs.push_back(o.alloc_offset);
      end else begin
         foreach (live_ptrs[i])
            if (live_ptrs[i] == r.data_offset) begin
               live_ptrs.delete(i);
               break;
            end
         freed_ptrs.push_back(r.data_offset);
         if (freed_ptrs.size() > 32) void'(freed_ptrs.pop_front());
      end
   endfunction

   task automatic send_req(input logic op, input int unsigned size,
                           input logic is_null, input int unsigned doff);
      req_type r;
      rsp_type o;
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      r.op          = op;
      r.size_bytes  = size[SizeWidth-1:0];
      r.ptr_null    = is_null;
      r.data_offset = doff[OffsetWidth-1:0];
      req_ch.payload = r;
      req_ch.valid   = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      o = heap_predict(r);
      pending_rsp.push_back(o);
      track_ptrs(r, o);
      burst_left--;
      @(negedge clock);
      if (burst_left == 0) req_ch.valid = 1'b0;
   endtask

   task automatic alloc_req(input int unsigned size);
      send_req(OP_ALLOC, size, 1'($urandom), $urandom_range(0, 20'hFFFFF));
   endtask

   task automatic free_req(input int unsigned doff);
      send_req(OP_FREE, $urandom_range(0, HeapBytes), 1'b0, doff);
   endtask

   task automatic wait_drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // whole heap in one block, then the size extremes
   task automatic test_size_extremes();
      alloc_req(HeapBytes - 16);
      free_req(16);
      alloc_req(HeapBytes);
      alloc_req(21'h1FFFFF);
      alloc_req(0);
      alloc_req(1);
      alloc_req(16);
      alloc_req(17);
   endtask

   task automatic test_bad_frees();
      send_req(OP_FREE, 0, 1'b1, 20'hFFFFF);
      free_req(0);
      free_req(8);
      free_req(20'hFFFFF);
      free_req(HeapBytes - 16);     // no block header at this granule
      free_req(HeapBytes - 32);
      free_req(32);
      free_req(48);
      free_req(48);                 // double free
   endtask

   // remainder of one granule unlinks the whole block, two granules splits
   task automatic test_split_edges();
      alloc_req(48);
      free_req(live_ptrs[live_ptrs.size()-1]);
      alloc_req(32);
      alloc_req(64);
      free_req(live_ptrs[live_ptrs.size()-1]);
      alloc_req(32);
   endtask

   // fill with large blocks until no fit, then hand them all back
   task automatic test_exhaustion();
      int unsigned n;
      n = live_ptrs.size();
      repeat (14) alloc_req(100000);
      alloc_req(50000);
      while (live_ptrs.size() > n) free_req(live_ptrs[live_ptrs.size()-1]);
   endtask

   task automatic test_random_mix();
      int unsigned pick, idx;
      repeat (RandomItems) begin
         pick = $urandom_range(0, 99);
         if (pick < 50 || (pick < 85 && live_ptrs.size() == 0)) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) alloc_req(0);
            else if (pick < 8) alloc_req($urandom_range(1, HeapBytes));
            else if (pick < 20) alloc_req($urandom_range(1024, 16384));
            else alloc_req($urandom_range(1, 1024));
         end else if (pick < 85) begin
            idx = $urandom_range(0, live_ptrs.size() - 1);
            free_req(live_ptrs[idx]);
         end else if (pick < 90 && freed_ptrs.size() != 0) begin
            free_req(freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)]);
         end else if (pick < 95) begin
            send_req(OP_FREE, $urandom_range(0, HeapBytes), 1'($urandom),
                     $urandom_range(0, 20'hFFFFF));
         end else begin
            send_req(OP_FREE, $urandom_range(0, HeapBytes), 1'b1,
                     $urandom_range(0, 20'hFFFFF));
         end
      end
   endtask

   // receiver: ready is redrawn at random on every falling edge, so stalls come at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response beat");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               error_count++;
            end
            if (got.alloc_offset !== want.alloc_offset) begin
               $error("alloc_offset: expected %0d, got %0d",
                      want.alloc_offset, got.alloc_offset);
               error_count++;
            end
            if (got.bytes_used !== want.bytes_used) begin
               $error("bytes_used: expected %0d, got %0d",
                      want.bytes_used, got.bytes_used);
               error_count++;
            end
            if (got.bytes_free !== want.bytes_free) begin
               $error("bytes_free: expected %0d, got %0d",
                      want.bytes_free, got.bytes_free);
               error_count++;
            end
            if (got.blocks_live !== want.blocks_live) begin
               $error("blocks_live: expected %0d, got %0d",
                      want.blocks_live, got.blocks_live);
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count    = 0;
      burst_left     = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      foreach (shadow_tag[i]) begin
         shadow_tag[i]  = TAG_NONE;
         shadow_len[i]  = 0;
         shadow_link[i] = 0;
      end
      shadow_tag[0]  = TAG_FREE;
      shadow_len[0]  = HeapGranules;
      shadow_link[0] = NilLink;
      free_head      = 0;
      shadow_used    = 0;
      shadow_free    = HeapBytes;
      live_count     = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_size_extremes();
      test_bad_frees();
      test_split_edges();
      test_exhaustion();
      test_random_mix();
      test_exhaustion();

      req_ch.valid = 1'b0;
      wait_drain();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_first_fit_heap_allocator: clean");
      end else begin
         $display("tb_first_fit_heap_allocator: errors");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_first_fit_heap_allocator: errors");
      $finish;
   end
endmodule
`default_nettype wire
